// ----- hdl/lc3_pkg.sv -----
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared codes, constants and helpers for the LC-3 instruction execute block.
// ----------------------------------------------------------------------------
package lc3_pkg;

    // Default memory depth in words
    localparam int MEM_WORDS_DEFAULT = 65536;

    // Program counter after reset and default restart address
    localparam logic [15:0] PC_RESET = 16'h3000;

    // Item opcodes
    localparam logic [1:0] ITEM_LOAD    = 2'd0;
    localparam logic [1:0] ITEM_EXECUTE = 2'd1;
    localparam logic [1:0] ITEM_RESTART = 2'd2;
    localparam logic [1:0] ITEM_NONE    = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_EXECUTED  = 2'd0;
    localparam logic [1:0] STAT_UNSUPPORT = 2'd1;
    localparam logic [1:0] STAT_LOADED    = 2'd2;
    localparam logic [1:0] STAT_RESTARTED = 2'd3;

    // Instruction opcodes (bits 15:12)
    localparam logic [3:0] OP_ADD = 4'd1;
    localparam logic [3:0] OP_LD  = 4'd2;
    localparam logic [3:0] OP_ST  = 4'd3;
    localparam logic [3:0] OP_JSR = 4'd4;
    localparam logic [3:0] OP_AND = 4'd5;
    localparam logic [3:0] OP_LDR = 4'd6;
    localparam logic [3:0] OP_STR = 4'd7;
    localparam logic [3:0] OP_NOT = 4'd9;
    localparam logic [3:0] OP_LDI = 4'd10;
    localparam logic [3:0] OP_STI = 4'd11;
    localparam logic [3:0] OP_JMP = 4'd12;
    localparam logic [3:0] OP_LEA = 4'd14;

    // Condition code bits
    localparam logic [2:0] FLAG_P = 3'd1;
    localparam logic [2:0] FLAG_Z = 3'd2;
    localparam logic [2:0] FLAG_N = 3'd4;

    // Link register for JSR/JSRR
    localparam logic [2:0] LINK_REG = 3'd7;

    // Condition code from a value written to a register
    function automatic logic [2:0] cc_of(input logic [15:0] v);
        logic [2:0] cc;
        if (v == 16'd0)
            cc = FLAG_Z;
        else if (v[15])
            cc = FLAG_N;
        else
            cc = FLAG_P;
        return cc;
    endfunction

endpackage

// ----- hdl/lc3_instruction_execute.sv -----
// ----------------------------------------------------------------------------
// lc3_instruction_execute
// LC-3 core: register file and word memory in synchronous RAMs, stepped one
// instruction per item by a sequencer with a single memory port.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ---------------------------------------
//  input     in_valid / in_stall     opcode, load_address, load_data
//  output    out_valid / out_stall   status, program_counter, cond_flags,
//                                    instruction, reg_written, reg_index,
//                                    reg_value, mem_written, mem_address,
//                                    mem_value
//  config    cfg_wr_en               cfg_wr_data (start address)
//
// Restart and unassigned items go straight to S_FINISH, a load after an
// address fold and memory write. An instruction is fetched, its operands
// read and then executed, with memory accesses for the loads and stores.
// Each memory access uses the single memory port (two-step address fold,
// then the access); the register file is read one operand a cycle through
// its one read port. Reset clears the register file (per-entry valid bits),
// PC = 0x3000, Z. A new item is taken once the previous result sits in the
// output register, even while out_stall holds it there; a finished result
// waits in S_FINISH while the output register is still held.

module lc3_instruction_execute #(
    parameter int MEM_WORDS = lc3_pkg::MEM_WORDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    // Input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] load_address,
    input  logic [15:0] load_data,

    // Result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] program_counter,
    output logic [2:0]  cond_flags,
    output logic [15:0] instruction,
    output logic        reg_written,
    output logic [2:0]  reg_index,
    output logic [15:0] reg_value,
    output logic        mem_written,
    output logic [15:0] mem_address,
    output logic [15:0] mem_value
);

    // Memory index width and reciprocal for folding 16-bit addresses
    localparam int          AW          = $clog2(MEM_WORDS);
    localparam logic [32:0] FOLD_RECIP  = 33'((64'd1 << 32) / MEM_WORDS + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FOLD1   = 4'd1;
    localparam logic [3:0] S_FOLD2   = 4'd2;
    localparam logic [3:0] S_MEM     = 4'd3;
    localparam logic [3:0] S_FETCHED = 4'd4;
    localparam logic [3:0] S_RDA     = 4'd5;
    localparam logic [3:0] S_RDB     = 4'd6;
    localparam logic [3:0] S_RDD     = 4'd7;
    localparam logic [3:0] S_EXEC    = 4'd8;
    localparam logic [3:0] S_MEMRD1  = 4'd9;
    localparam logic [3:0] S_MEMRD2  = 4'd10;
    localparam logic [3:0] S_FINISH  = 4'd11;

    // Control state
    logic [3:0]  state_reg, state_next;
    logic [3:0]  ret_reg, ret_next;
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  cc_reg, cc_next;
    logic [15:0] start_reg, start_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  rf_valid_reg, rf_valid_next;

    // Working payload
    logic [15:0] addr_reg, addr_next;
    logic [15:0] wdata_reg, wdata_next;
    logic        mem_wr_reg, mem_wr_next;
    logic [15:0] q_reg, q_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [15:0] instr_reg, instr_next;
    logic [15:0] a_reg, a_next;
    logic [15:0] b_reg, b_next;
    logic [15:0] d_reg, d_next;

    // Pending result
    logic [1:0]  res_status_reg, res_status_next;
    logic        res_rw_reg, res_rw_next;
    logic [2:0]  res_ridx_reg, res_ridx_next;
    logic [15:0] res_rval_reg, res_rval_next;
    logic        res_mw_reg, res_mw_next;
    logic [15:0] res_maddr_reg, res_maddr_next;
    logic [15:0] res_mval_reg, res_mval_next;

    // Output register
    logic [1:0]  out_status_reg;
    logic [15:0] out_pc_reg;
    logic [2:0]  out_cc_reg;
    logic [15:0] out_instr_reg;
    logic        out_rw_reg;
    logic [2:0]  out_ridx_reg;
    logic [15:0] out_rval_reg;
    logic        out_mw_reg;
    logic [15:0] out_maddr_reg;
    logic [15:0] out_mval_reg;
    logic        out_load;

    // Memories
    logic [15:0] mem [MEM_WORDS];
    logic [15:0] mem_rdata_reg;
    logic        mem_access;
    logic [15:0] rf [8];
    logic [15:0] rf_rdata_reg;
    logic [2:0]  rf_rd_idx;
    logic        rf_we;
    logic [2:0]  rf_wr_idx;
    logic [15:0] rf_wdata;

    // Decode helpers
    logic        in_accept;
    logic [3:0]  code;
    logic [2:0]  dr;
    logic [15:0] imm5, off6, off9, off11;
    logic [15:0] pc_off9, pc_off11, base_off6;
    logic [15:0] alu_b, alu_val;
    logic [48:0] fold_prod;
    logic [31:0] fold_qm;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);

    assign code  = instr_reg[15:12];
    assign dr    = instr_reg[11:9];
    assign imm5  = {{11{instr_reg[4]}}, instr_reg[4:0]};
    assign off6  = {{10{instr_reg[5]}}, instr_reg[5:0]};
    assign off9  = {{7{instr_reg[8]}}, instr_reg[8:0]};
    assign off11 = {{5{instr_reg[10]}}, instr_reg[10:0]};

    // PC here is already incremented past the fetched word
    assign pc_off9   = pc_reg + off9;
    assign pc_off11  = pc_reg + off11;
    assign base_off6 = a_reg + off6;

    // ADD / AND / NOT result
    assign alu_b = instr_reg[5] ? imm5 : b_reg;
    always_comb
    begin
        case (code)
            lc3_pkg::OP_ADD: alu_val = a_reg + alu_b;
            lc3_pkg::OP_AND: alu_val = a_reg & alu_b;
            lc3_pkg::OP_NOT: alu_val = ~a_reg;
            default:         alu_val = pc_off9;
        endcase
    end

    // Address fold: quotient by reciprocal, then remainder
    assign fold_prod = 49'(addr_reg) * 49'(FOLD_RECIP);
    assign fold_qm   = 32'(q_reg) * 32'(MEM_WORDS);

    assign mem_access = (state_reg == S_MEM);
    assign out_load   = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        pc_next         = pc_reg;
        cc_next         = cc_reg;
        start_next      = cfg_wr_en ? cfg_wr_data : start_reg;
        rf_valid_next   = rf_valid_reg;
        addr_next       = addr_reg;
        wdata_next      = wdata_reg;
        mem_wr_next     = mem_wr_reg;
        q_next          = q_reg;
        idx_next        = idx_reg;
        instr_next      = instr_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        d_next          = d_reg;
        res_status_next = res_status_reg;
        res_rw_next     = res_rw_reg;
        res_ridx_next   = res_ridx_reg;
        res_rval_next   = res_rval_reg;
        res_mw_next     = res_mw_reg;
        res_maddr_next  = res_maddr_reg;
        res_mval_next   = res_mval_reg;
        rf_rd_idx       = instr_reg[8:6];
        rf_we           = 1'b0;
        rf_wr_idx       = dr;
        rf_wdata        = alu_val;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    instr_next      = '0;
                    res_status_next = lc3_pkg::STAT_EXECUTED;
                    res_rw_next     = 1'b0;
                    res_ridx_next   = '0;
                    res_rval_next   = '0;
                    res_mw_next     = 1'b0;
                    res_maddr_next  = '0;
                    res_mval_next   = '0;
                    case (opcode)
                        lc3_pkg::ITEM_LOAD:
                        begin
                            res_status_next = lc3_pkg::STAT_LOADED;
                            addr_next       = load_address;
                            wdata_next      = load_data;
                            mem_wr_next     = 1'b1;
                            ret_next        = S_FINISH;
                            state_next      = S_FOLD1;
                        end
                        lc3_pkg::ITEM_EXECUTE:
                        begin
                            addr_next   = pc_reg;
                            mem_wr_next = 1'b0;
                            ret_next    = S_FETCHED;
                            state_next  = S_FOLD1;
                        end
                        lc3_pkg::ITEM_RESTART:
                        begin
                            res_status_next = lc3_pkg::STAT_RESTARTED;
                            pc_next         = start_reg;
                            cc_next         = lc3_pkg::FLAG_Z;
                            state_next      = S_FINISH;
                        end
                        default:
                        begin
                            res_status_next = lc3_pkg::STAT_UNSUPPORT;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
            end

            S_FOLD1:
            begin
                q_next     = fold_prod[47:32];
                state_next = S_FOLD2;
            end

            S_FOLD2:
            begin
                idx_next   = AW'(addr_reg - fold_qm[15:0]);
                state_next = S_MEM;
            end

            S_MEM:
            begin
                state_next = ret_reg;
            end

            // Instruction word back: advance PC, read first operand
            S_FETCHED:
            begin
                instr_next = mem_rdata_reg;
                pc_next    = pc_reg + 16'd1;
                rf_rd_idx  = mem_rdata_reg[8:6];
                state_next = S_RDA;
            end

            S_RDA:
            begin
                a_next     = rf_rdata_reg;
                rf_rd_idx  = instr_reg[2:0];
                state_next = S_RDB;
            end

            S_RDB:
            begin
                b_next     = rf_rdata_reg;
                rf_rd_idx  = dr;
                state_next = S_RDD;
            end

            S_RDD:
            begin
                d_next     = rf_rdata_reg;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next = S_FINISH;
                case (code)
                    lc3_pkg::OP_ADD, lc3_pkg::OP_AND, lc3_pkg::OP_NOT, lc3_pkg::OP_LEA:
                    begin
                        rf_we         = 1'b1;
                        rf_valid_next = rf_valid_reg | (8'd1 << dr);
                        cc_next       = lc3_pkg::cc_of(alu_val);
                        res_rw_next   = 1'b1;
                        res_ridx_next = dr;
                        res_rval_next = alu_val;
                    end
                    lc3_pkg::OP_JMP:
                    begin
                        pc_next = a_reg;
                    end
                    // Link write leaves the condition code alone
                    lc3_pkg::OP_JSR:
                    begin
                        rf_we         = 1'b1;
                        rf_wr_idx     = lc3_pkg::LINK_REG;
                        rf_wdata      = pc_reg;
                        rf_valid_next = rf_valid_reg | (8'd1 << lc3_pkg::LINK_REG);
                        pc_next       = instr_reg[11] ? pc_off11 : a_reg;
                        res_rw_next   = 1'b1;
                        res_ridx_next = lc3_pkg::LINK_REG;
                        res_rval_next = pc_reg;
                    end
                    lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_STI:
                    begin
                        addr_next   = pc_off9;
                        mem_wr_next = 1'b0;
                        ret_next    = S_MEMRD1;
                        state_next  = S_FOLD1;
                    end
                    lc3_pkg::OP_LDR:
                    begin
                        addr_next   = base_off6;
                        mem_wr_next = 1'b0;
                        ret_next    = S_MEMRD1;
                        state_next  = S_FOLD1;
                    end
                    lc3_pkg::OP_ST, lc3_pkg::OP_STR:
                    begin
                        addr_next      = (code == lc3_pkg::OP_ST) ? pc_off9 : base_off6;
                        wdata_next     = d_reg;
                        mem_wr_next    = 1'b1;
                        res_mw_next    = 1'b1;
                        res_maddr_next = (code == lc3_pkg::OP_ST) ? pc_off9 : base_off6;
                        res_mval_next  = d_reg;
                        ret_next       = S_FINISH;
                        state_next     = S_FOLD1;
                    end
                    default:
                    begin
                        res_status_next = lc3_pkg::STAT_UNSUPPORT;
                    end
                endcase
            end

            // First memory word back for loads and STI
            S_MEMRD1:
            begin
                state_next = S_FINISH;
                case (code)
                    lc3_pkg::OP_LDI:
                    begin
                        addr_next  = mem_rdata_reg;
                        ret_next   = S_MEMRD2;
                        state_next = S_FOLD1;
                    end
                    lc3_pkg::OP_STI:
                    begin
                        addr_next      = mem_rdata_reg;
                        wdata_next     = d_reg;
                        mem_wr_next    = 1'b1;
                        res_mw_next    = 1'b1;
                        res_maddr_next = mem_rdata_reg;
                        res_mval_next  = d_reg;
                        ret_next       = S_FINISH;
                        state_next     = S_FOLD1;
                    end
                    default:
                    begin
                        rf_we         = 1'b1;
                        rf_wdata      = mem_rdata_reg;
                        rf_valid_next = rf_valid_reg | (8'd1 << dr);
                        cc_next       = lc3_pkg::cc_of(mem_rdata_reg);
                        res_rw_next   = 1'b1;
                        res_ridx_next = dr;
                        res_rval_next = mem_rdata_reg;
                    end
                endcase
            end

            // Indirect load data back
            S_MEMRD2:
            begin
                rf_we         = 1'b1;
                rf_wdata      = mem_rdata_reg;
                rf_valid_next = rf_valid_reg | (8'd1 << dr);
                cc_next       = lc3_pkg::cc_of(mem_rdata_reg);
                res_rw_next   = 1'b1;
                res_ridx_next = dr;
                res_rval_next = mem_rdata_reg;
                state_next    = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared once taken
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            pc_reg        <= lc3_pkg::PC_RESET;
            cc_reg        <= lc3_pkg::FLAG_Z;
            start_reg     <= lc3_pkg::PC_RESET;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            pc_reg        <= pc_next;
            cc_reg        <= cc_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            rf_valid_reg  <= rf_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        wdata_reg      <= wdata_next;
        mem_wr_reg     <= mem_wr_next;
        q_reg          <= q_next;
        idx_reg        <= idx_next;
        instr_reg      <= instr_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        d_reg          <= d_next;
        res_status_reg <= res_status_next;
        res_rw_reg     <= res_rw_next;
        res_ridx_reg   <= res_ridx_next;
        res_rval_reg   <= res_rval_next;
        res_mw_reg     <= res_mw_next;
        res_maddr_reg  <= res_maddr_next;
        res_mval_reg   <= res_mval_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_pc_reg     <= pc_reg;
            out_cc_reg     <= cc_reg;
            out_instr_reg  <= instr_reg;
            out_rw_reg     <= res_rw_reg;
            out_ridx_reg   <= res_ridx_reg;
            out_rval_reg   <= res_rval_reg;
            out_mw_reg     <= res_mw_reg;
            out_maddr_reg  <= res_maddr_reg;
            out_mval_reg   <= res_mval_reg;
        end
    end

    // Main memory: one port, read or write per access
    always_ff @(posedge clk)
    begin
        if (mem_access)
        begin
            if (mem_wr_reg)
                mem[idx_reg] <= wdata_reg;
            else
                mem_rdata_reg <= mem[idx_reg];
        end
    end

    // Register file: one write and one read port; unwritten entries read zero
    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[rf_wr_idx] <= rf_wdata;
        rf_rdata_reg <= rf_valid_reg[rf_rd_idx] ? rf[rf_rd_idx] : 16'd0;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign program_counter = out_pc_reg;
    assign cond_flags      = out_cc_reg;
    assign instruction     = out_instr_reg;
    assign reg_written     = out_rw_reg;
    assign reg_index       = out_ridx_reg;
    assign reg_value       = out_rval_reg;
    assign mem_written     = out_mw_reg;
    assign mem_address     = out_maddr_reg;
    assign mem_value       = out_mval_reg;

endmodule

// ----- bench/lc3_instruction_execute_test.sv -----
// ----------------------------------------------------------------------------
// lc3_instruction_execute_test
// Self-checking bench for the LC-3 execute block. A per-item state
// predictor (registers, PC, condition code, word memory) runs next to the
// block. An executed instruction follows loads of its fetch word and data,
// or reads only words found written, so no unwritten word is ever read.
// Traffic runs through three stall mixes at three restart addresses.
// ----------------------------------------------------------------------------
module lc3_instruction_execute_test;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int QUIET_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;
    localparam int ITEMS_PER_PHASE = 460;

    // One result item, fields in port order
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pc;
        logic [2:0]  cc;
        logic [15:0] instr;
        logic        rw;
        logic [2:0]  ridx;
        logic [15:0] rval;
        logic        mw;
        logic [15:0] maddr;
        logic [15:0] mval;
    } step_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: architectural state plus the queue of predicted results
    // ------------------------------------------------------------------------
    class lc3_step_scoreboard;
        logic [15:0]  gpr [8];
        logic [15:0]  pc;
        logic [15:0]  restart_pc;
        logic [2:0]   cc;
        bit   [15:0]  mem_word [65536];
        bit           mem_valid [65536];
        step_result_t predicted_results [$];
        int           checked;
        int           mismatches;
        int           executed;

        function new();
            foreach (gpr[i])
                gpr[i] = '0;
            pc         = lc3_pkg::PC_RESET;
            restart_pc = lc3_pkg::PC_RESET;
            cc         = lc3_pkg::FLAG_Z;
            checked    = 0;
            mismatches = 0;
            executed   = 0;
        endfunction

        function logic [15:0] sign_ext(logic [15:0] v, int bits);
            logic [15:0] t;
            t = v << (16 - bits);
            return $signed(t) >>> (16 - bits);
        endfunction

        // True if fetching and executing at the current PC only reads written words
        function bit exec_reads_ok();
            logic [15:0] ir;
            logic [15:0] ea;
            bit          ok;
            ok = mem_valid[pc];
            ir = mem_word[pc];
            ea = pc + 16'd1 + sign_ext(ir, 9);
            if (ok)
            begin
                case (ir[15:12])
                    lc3_pkg::OP_LD, lc3_pkg::OP_STI:
                        ok = mem_valid[ea];
                    lc3_pkg::OP_LDI:
                        ok = mem_valid[ea] && mem_valid[mem_word[ea]];
                    lc3_pkg::OP_LDR:
                    begin
                        ea = gpr[ir[8:6]] + sign_ext(ir, 6);
                        ok = mem_valid[ea];
                    end
                    default:
                        ok = 1'b1;
                endcase
            end
            return ok;
        endfunction

        // Advance the state by one accepted item and queue its result
        function void note_item(logic [1:0] op, logic [15:0] addr, logic [15:0] data);
            step_result_t r;
            logic [15:0]  ir;
            logic [15:0]  next_pc;
            logic [15:0]  ea;
            logic [15:0]  b;
            logic [3:0]   code;
            logic [2:0]   dr;
            logic [2:0]   sr1;
            r = '0;
            case (op)
                lc3_pkg::ITEM_LOAD:
                begin
                    mem_word[addr]  = data;
                    mem_valid[addr] = 1'b1;
                    r.status        = lc3_pkg::STAT_LOADED;
                end
                lc3_pkg::ITEM_RESTART:
                begin
                    pc       = restart_pc;
                    cc       = lc3_pkg::FLAG_Z;
                    r.status = lc3_pkg::STAT_RESTARTED;
                end
                lc3_pkg::ITEM_EXECUTE:
                begin
                    ir       = mem_word[pc];
                    pc       = pc + 16'd1;
                    next_pc  = pc;
                    code     = ir[15:12];
                    dr       = ir[11:9];
                    sr1      = ir[8:6];
                    r.status = lc3_pkg::STAT_EXECUTED;
                    r.instr  = ir;
                    executed++;
                    case (code)
                        lc3_pkg::OP_ADD, lc3_pkg::OP_AND:
                        begin
                            b      = ir[5] ? sign_ext(ir, 5) : gpr[ir[2:0]];
                            r.rval = (code == lc3_pkg::OP_ADD) ? gpr[sr1] + b
                                                               : gpr[sr1] & b;
                            r.rw   = 1'b1;
                            r.ridx = dr;
                        end
                        lc3_pkg::OP_NOT:
                        begin
                            r.rval = ~gpr[sr1];
                            r.rw   = 1'b1;
                            r.ridx = dr;
                        end
                        lc3_pkg::OP_JMP:
                            pc = gpr[sr1];
                        lc3_pkg::OP_JSR:
                        begin
                            // target taken before the link overwrites R7
                            pc     = ir[11] ? next_pc + sign_ext(ir, 11) : gpr[sr1];
                            gpr[lc3_pkg::LINK_REG] = next_pc;
                            r.rw   = 1'b1;
                            r.ridx = lc3_pkg::LINK_REG;
                            r.rval = next_pc;
                        end
                        lc3_pkg::OP_LD:
                        begin
                            ea     = next_pc + sign_ext(ir, 9);
                            r.rval = mem_word[ea];
                            r.rw   = 1'b1;
                            r.ridx = dr;
                        end
                        lc3_pkg::OP_LDI:
                        begin
                            ea     = next_pc + sign_ext(ir, 9);
                            r.rval = mem_word[mem_word[ea]];
                            r.rw   = 1'b1;
                            r.ridx = dr;
                        end
                        lc3_pkg::OP_LDR:
                        begin
                            ea     = gpr[sr1] + sign_ext(ir, 6);
                            r.rval = mem_word[ea];
                            r.rw   = 1'b1;
                            r.ridx = dr;
                        end
                        lc3_pkg::OP_LEA:
                        begin
                            r.rval = next_pc + sign_ext(ir, 9);
                            r.rw   = 1'b1;
                            r.ridx = dr;
                        end
                        lc3_pkg::OP_ST:
                        begin
                            r.maddr = next_pc + sign_ext(ir, 9);
                            r.mw    = 1'b1;
                        end
                        lc3_pkg::OP_STI:
                        begin
                            ea      = next_pc + sign_ext(ir, 9);
                            r.maddr = mem_word[ea];
                            r.mw    = 1'b1;
                        end
                        lc3_pkg::OP_STR:
                        begin
                            r.maddr = gpr[sr1] + sign_ext(ir, 6);
                            r.mw    = 1'b1;
                        end
                        default:
                            r.status = lc3_pkg::STAT_UNSUPPORT;
                    endcase
                    if (r.mw)
                    begin
                        r.mval             = gpr[dr];
                        mem_word[r.maddr]  = r.mval;
                        mem_valid[r.maddr] = 1'b1;
                    end
                    // the JSR link leaves the condition code alone
                    if (r.rw && code != lc3_pkg::OP_JSR)
                    begin
                        gpr[r.ridx] = r.rval;
                        if (r.rval == 16'd0)
                            cc = lc3_pkg::FLAG_Z;
                        else if (r.rval[15])
                            cc = lc3_pkg::FLAG_N;
                        else
                            cc = lc3_pkg::FLAG_P;
                    end
                end
                default:
                    r.status = lc3_pkg::STAT_UNSUPPORT;
            endcase
            r.pc = pc;
            r.cc = cc;
            predicted_results.push_back(r);
        endfunction

        function string describe(step_result_t r);
            return $sformatf("st=%0d pc=%h cc=%0d ir=%h rw=%0d r%0d=%h mw=%0d [%h]=%h",
                             r.status, r.pc, r.cc, r.instr, r.rw, r.ridx, r.rval,
                             r.mw, r.maddr, r.mval);
        endfunction

        function void check_result(step_result_t got);
            step_result_t want;
            string        bad;
            checked++;
            if (predicted_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with none expected: %s",
                             checked, describe(got));
                return;
            end
            want = predicted_results.pop_front();
            bad  = "";
            if (got.status !== want.status) bad = {bad, " status"};
            if (got.pc !== want.pc)         bad = {bad, " program_counter"};
            if (got.cc !== want.cc)         bad = {bad, " cond_flags"};
            if (got.instr !== want.instr)   bad = {bad, " instruction"};
            if (got.rw !== want.rw)         bad = {bad, " reg_written"};
            if (got.ridx !== want.ridx)     bad = {bad, " reg_index"};
            if (got.rval !== want.rval)     bad = {bad, " reg_value"};
            if (got.mw !== want.mw)         bad = {bad, " mem_written"};
            if (got.maddr !== want.maddr)   bad = {bad, " mem_address"};
            if (got.mval !== want.mval)     bad = {bad, " mem_value"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("result %0d mismatch in%s", checked, bad);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction

        function int pending();
            return predicted_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [15:0] cfg_wr_data  = '0;
    logic        in_valid     = 1'b0;
    logic [1:0]  opcode       = '0;
    logic [15:0] load_address = '0;
    logic [15:0] load_data    = '0;
    logic        out_stall    = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  status;
    logic [15:0] program_counter;
    logic [2:0]  cond_flags;
    logic [15:0] instruction;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [15:0] mem_value;

    lc3_step_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    lc3_instruction_execute u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .load_address    (load_address),
        .load_data       (load_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .program_counter (program_counter),
        .cond_flags      (cond_flags),
        .instruction     (instruction),
        .reg_written     (reg_written),
        .reg_index       (reg_index),
        .reg_value       (reg_value),
        .mem_written     (mem_written),
        .mem_address     (mem_address),
        .mem_value       (mem_value)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Timeout
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("lc3_instruction_execute_test: FAIL");
        $finish;
    end

    // Result side: check accepted results, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({status, program_counter, cond_flags, instruction,
                             reg_written, reg_index, reg_value,
                             mem_written, mem_address, mem_value});
        if (hold_off_left > 0)
        begin
            out_stall <= 1'b1;
            hold_off_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one item, hold it until taken, then update the predictor
    task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                             input logic [15:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        load_address <= addr;
        load_data    <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(op, addr, data);
        if (op != lc3_pkg::ITEM_NONE)
            items_sent++;
    endtask

    // Wait until every predicted result is back, plus settling time
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_address(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        sb.restart_pc = v;
    endtask

    // Load the data an instruction reads, the instruction itself, then run it
    task automatic exec_word(input logic [15:0] word);
        logic [15:0] here;
        logic [15:0] ea;
        logic [15:0] ptr;
        here = sb.pc;
        ea   = here + 16'd1 + sb.sign_ext(word, 9);
        ptr  = 16'($urandom);
        case (word[15:12])
            lc3_pkg::OP_LD, lc3_pkg::OP_STI:
                send_item(lc3_pkg::ITEM_LOAD, ea, ptr);
            lc3_pkg::OP_LDI:
            begin
                send_item(lc3_pkg::ITEM_LOAD, ea, ptr);
                send_item(lc3_pkg::ITEM_LOAD, ptr, 16'($urandom));
            end
            lc3_pkg::OP_LDR:
            begin
                ea = sb.gpr[word[8:6]] + sb.sign_ext(word, 6);
                send_item(lc3_pkg::ITEM_LOAD, ea, ptr);
            end
            default:
                ;
        endcase
        send_item(lc3_pkg::ITEM_LOAD, here, word);
        // an overlap clobbered a needed word: fall back to a register-only op
        if (!sb.exec_reads_ok())
            send_item(lc3_pkg::ITEM_LOAD, here, {lc3_pkg::OP_NOT, 12'($urandom)});
        send_item(lc3_pkg::ITEM_EXECUTE, 16'($urandom), 16'($urandom));
    endtask

    // Random traffic: mostly prepared instructions, some noise
    task automatic run_random(input int n_items);
        int stop_at;
        int pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 72)
            begin
                // sometimes run whatever already sits at the PC
                if (sb.exec_reads_ok() && $urandom_range(2) == 0)
                    send_item(lc3_pkg::ITEM_EXECUTE, 16'($urandom), 16'($urandom));
                else
                    exec_word(16'($urandom));
            end
            else if (pick < 87)
                send_item(lc3_pkg::ITEM_LOAD, 16'($urandom), 16'($urandom));
            else if (pick < 94)
                send_item(lc3_pkg::ITEM_RESTART, 16'($urandom), 16'($urandom));
            else
                send_item(lc3_pkg::ITEM_NONE, 16'($urandom), 16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, flag outcomes, indirect access, links
        send_item(lc3_pkg::ITEM_LOAD, 16'hFFFF, 16'hFFFF);
        send_item(lc3_pkg::ITEM_LOAD, 16'h0000, 16'h0000);
        exec_word({lc3_pkg::OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10});       // most negative imm
        exec_word({lc3_pkg::OP_ADD, 3'd2, 3'd1, 1'b1, 5'h0F});       // most positive imm
        exec_word({lc3_pkg::OP_AND, 3'd3, 3'd2, 1'b0, 2'b00, 3'd1}); // register operand
        exec_word({lc3_pkg::OP_AND, 3'd0, 3'd1, 1'b1, 5'h00});       // result zero
        exec_word({lc3_pkg::OP_NOT, 3'd4, 3'd3, 6'h3F});
        exec_word({lc3_pkg::OP_LDI, 3'd5, 9'h0FF});
        exec_word({lc3_pkg::OP_STI, 3'd4, 9'h100});
        exec_word({lc3_pkg::OP_JSR, 1'b1, 11'h400});                 // JSR, farthest back
        exec_word({lc3_pkg::OP_JSR, 1'b0, 2'b00, 3'd7, 6'h00});      // JSRR through R7
        exec_word({4'hF, 12'h025});                                  // unsupported
        send_item(lc3_pkg::ITEM_NONE, 16'hFFFF, 16'hFFFF);
        send_item(lc3_pkg::ITEM_RESTART, 16'h0000, 16'h0000);
        drain_results();

        // Sender idles lightly, receiver stalls often; PC wraps from the top
        write_start_address(16'hFFFF);
        send_idle_pct  = 10;
        recv_stall_pct = 52;
        send_item(lc3_pkg::ITEM_RESTART, 16'($urandom), 16'($urandom));
        run_random(ITEMS_PER_PHASE);
        drain_results();

        // Sender idles often, receiver stalls lightly
        write_start_address(16'h0000);
        send_idle_pct  = 52;
        recv_stall_pct = 10;
        send_item(lc3_pkg::ITEM_RESTART, 16'($urandom), 16'($urandom));
        run_random(ITEMS_PER_PHASE);
        drain_results();

        // Full rate, opening with a long receiver hold-off so the input backs up
        write_start_address(16'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = HOLD_OFF_CYCLES;
        send_item(lc3_pkg::ITEM_RESTART, 16'($urandom), 16'($urandom));
        run_random(ITEMS_PER_PHASE);
        drain_results();

        $display("summary: %0d items sent, %0d instructions executed, %0d results checked",
                 items_sent, sb.executed, sb.checked);
        $display("summary: start addresses 0x3000, 0xFFFF, 0x0000 and one random; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("lc3_instruction_execute_test: PASS");
        else
            $display("lc3_instruction_execute_test: FAIL");
        $finish;
    end

endmodule
